FILE: rtl/bpfa_pkg.sv
// ---------------------------------------------------------------------------
// Bitmap page frame allocator package
// Sizes, operation codes, transfer payload types and state encoding shared
// by the allocator RTL.
// ---------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

  // Number of physical pages managed by the allocator.
  localparam int PAGE_TOTAL = 4096;

  // Bitmap organisation: one 64-bit word per row of the occupancy memory.
  localparam int WORD_BITS  = 64;
  localparam int PAGE_BITS  = $clog2(WORD_BITS);
  localparam int PAGE_WORDS = (PAGE_TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W    = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;

  // Field widths fixed by the interface.
  localparam int OP_W       = 3;
  localparam int IDX_W      = 12;
  localparam int CNT_W      = 13;

  // The search hint must be able to hold PAGE_TOTAL itself (search exhausted).
  localparam int HINT_W     = $clog2(PAGE_TOTAL + 1);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_REQUEST   = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
  localparam logic [OP_W-1:0] OP_LOCK      = 3'd2;
  localparam logic [OP_W-1:0] OP_RESERVE   = 3'd3;
  localparam logic [OP_W-1:0] OP_UNRESERVE = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] page_index;
  } bpfa_in_t;

  typedef struct packed {
    logic             done_res;
    logic [IDX_W-1:0] alloc_page;
    logic [CNT_W-1:0] pages_free;
    logic [CNT_W-1:0] used_pages;
    logic [CNT_W-1:0] reserved_pages;
  } bpfa_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } bpfa_state_t;

endpackage

`default_nettype wire

FILE: rtl/bitmap_page_frame_allocator_unit.sv
// ---------------------------------------------------------------------------
// Bitmap page frame allocator
// Occupancy bitmap in a synchronous memory with read-modify-write control,
// a next-free search hint and free, used and reserved page counters.
// ---------------------------------------------------------------------------
// Sequence: an accepted item passes through ST_READ (bitmap row read) and
//   ST_EVAL (write, counters and result load); a request returns to ST_READ
//   for each full bitmap word it steps over. ST_EVAL waits while the result
//   register is still full. One item is worked on at a time.
// Reset: synchronous; the bitmap reads as all clear through per-row valid
//   bits, the hint and used/reserved counters clear, free = PAGE_TOTAL.
`default_nettype none

module bitmap_page_frame_allocator_unit import bpfa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire bpfa_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output bpfa_out_t      out_data
);

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  bpfa_state_t          state, state_next;

  // Item being worked on, captured at the input transfer.
  logic [OP_W-1:0]      cur_op;
  logic [IDX_W-1:0]     cur_page;

  // Row of the bitmap that the current read addressed; also the write row.
  logic [WADDR_W-1:0]   cur_wa;

  logic [HINT_W-1:0]    hint, hint_next;
  logic [CNT_W-1:0]     free_cnt, free_cnt_next;
  logic [CNT_W-1:0]     used_cnt, used_cnt_next;
  logic [CNT_W-1:0]     rsvd_cnt, rsvd_cnt_next;

  // Occupancy memory. Rows never written since reset read as all clear,
  // which the per-row valid bits take care of.
  logic [WORD_BITS-1:0] bitmap_mem [PAGE_WORDS];
  logic [PAGE_WORDS-1:0] row_valid;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_valid;

  // -------------------------------------------------------------------------
  // Combinational control
  // -------------------------------------------------------------------------
  logic                 rd_en;
  logic [WADDR_W-1:0]   rd_addr;
  logic                 mem_we;
  logic [WORD_BITS-1:0] wr_data;
  logic                 load_out;
  bpfa_out_t            res_next;

  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] below_mask;
  logic [WORD_BITS-1:0] masked;
  logic [PAGE_BITS-1:0] zpos;
  logic                 zfound;
  logic                 out_free;
  logic [HINT_W-1:0]    page_ext;
  logic [HINT_W-1:0]    hint_step;
  logic                 page_ok;
  logic                 cur_bit;
  logic                 target;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // The word as it stands in the bitmap.
  assign word       = rd_valid ? rd_data : '0;
  assign page_ext   = HINT_W'(cur_page);
  assign page_ok    = page_ext < HINT_W'(PAGE_TOTAL);
  assign cur_bit    = word[cur_page[PAGE_BITS-1:0]];

  // For a scan, pages below the hint inside its word count as taken, so the
  // search starts exactly at the hint.
  assign below_mask = (WORD_BITS'(1) << hint[PAGE_BITS-1:0]) - WORD_BITS'(1);
  assign masked     = word | below_mask;
  assign zfound     = ~&masked;

  // Hint moved to the first page of the following word.
  assign hint_step  = {hint[HINT_W-1:PAGE_BITS], {PAGE_BITS{1'b1}}} + HINT_W'(1);

  // Lowest clear bit of the masked word.
  always_comb begin
    zpos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        zpos = PAGE_BITS'(i);
      end
    end
  end

  always_comb begin
    target = 1'b0;
    case (cur_op) inside
      OP_LOCK, OP_RESERVE: target = 1'b1;
      default:             target = 1'b0;
    endcase
  end

  always_comb begin
    state_next    = state;
    rd_en         = 1'b0;
    rd_addr       = page_ext[PAGE_BITS +: WADDR_W];
    mem_we        = 1'b0;
    wr_data       = word;
    load_out      = 1'b0;
    hint_next     = hint;
    free_cnt_next = free_cnt;
    used_cnt_next = used_cnt;
    rsvd_cnt_next = rsvd_cnt;

    res_next.done_res       = 1'b0;
    res_next.alloc_page     = '0;
    res_next.pages_free     = free_cnt;
    res_next.used_pages     = used_cnt;
    res_next.reserved_pages = rsvd_cnt;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
        end
      end

      ST_READ: begin
        // Fetch the row holding the hint (request) or the addressed page.
        rd_en = 1'b1;
        if (cur_op == OP_REQUEST) begin
          rd_addr = hint[PAGE_BITS +: WADDR_W];
        end
        state_next = ST_EVAL;
      end

      ST_EVAL: begin
        if (cur_op == OP_REQUEST && hint < HINT_W'(PAGE_TOTAL) && !zfound) begin
          // Whole word taken: step the hint on and read the next row.
          hint_next  = hint_step;
          state_next = ST_READ;
        end else if (out_free) begin
          // Result register free: commit the write and the counters together.
          load_out   = 1'b1;
          state_next = ST_IDLE;
          if (cur_op == OP_REQUEST) begin
            if (hint < HINT_W'(PAGE_TOTAL)) begin
              mem_we        = 1'b1;
              wr_data       = word | (WORD_BITS'(1) << zpos);
              hint_next     = {hint[HINT_W-1:PAGE_BITS], zpos};
              free_cnt_next = free_cnt - CNT_W'(1);
              used_cnt_next = used_cnt + CNT_W'(1);
              res_next.done_res   = 1'b1;
              res_next.alloc_page = IDX_W'({hint[HINT_W-1:PAGE_BITS], zpos});
            end
          end else if (cur_op <= OP_UNRESERVE && page_ok && cur_bit != target) begin
            mem_we  = 1'b1;
            res_next.done_res = 1'b1;
            if (target) begin
              wr_data       = word | (WORD_BITS'(1) << cur_page[PAGE_BITS-1:0]);
              free_cnt_next = free_cnt - CNT_W'(1);
              if (cur_op == OP_LOCK) begin
                used_cnt_next = used_cnt + CNT_W'(1);
              end else begin
                rsvd_cnt_next = rsvd_cnt + CNT_W'(1);
              end
            end else begin
              wr_data       = word & ~(WORD_BITS'(1) << cur_page[PAGE_BITS-1:0]);
              free_cnt_next = free_cnt + CNT_W'(1);
              // A freed reserved page is counted off the used pages.
              if (cur_op == OP_FREE) begin
                used_cnt_next = used_cnt - CNT_W'(1);
              end else begin
                rsvd_cnt_next = rsvd_cnt - CNT_W'(1);
              end
              if (hint > page_ext) begin
                hint_next = page_ext;
              end
            end
          end
          res_next.pages_free     = free_cnt_next;
          res_next.used_pages     = used_cnt_next;
          res_next.reserved_pages = rsvd_cnt_next;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // State and counters
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      hint     <= '0;
      free_cnt <= CNT_W'(PAGE_TOTAL);
      used_cnt <= '0;
      rsvd_cnt <= '0;
    end else begin
      state    <= state_next;
      hint     <= hint_next;
      free_cnt <= free_cnt_next;
      used_cnt <= used_cnt_next;
      rsvd_cnt <= rsvd_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_op   <= in_data.op;
      cur_page <= in_data.page_index;
    end
    if (rd_en) begin
      cur_wa <= rd_addr;
    end
  end

  // -------------------------------------------------------------------------
  // Occupancy memory: one read port, one write port, registered read data.
  // The read of an item always follows the previous write, with ST_IDLE
  // between them, so no forwarding path is required.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[cur_wa] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= bitmap_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (mem_we) begin
        row_valid[cur_wa] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= row_valid[rd_addr];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result register: holds a finished result until its transfer, while the
  // next item is already accepted and read.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res_next;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // The hint never runs past the end of the bitmap.
  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    hint <= HINT_W'(PAGE_TOTAL))
    else $error("search hint beyond the last page");

  // The bitmap is only written when the result can be taken at once.
  a_write_with_result: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (load_out && out_free))
    else $error("bitmap written without a result slot");

  // A result with a nonzero granted page always carries the done flag.
  a_grant_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.alloc_page != '0) |-> out_data.done_res)
    else $error("page granted without done flag");

  // An accepted item always starts with a memory read.
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_READ))
    else $error("accepted item did not start a read");

endmodule

`default_nettype wire
